// ----- hw/rtl/xtea_pkg.sv -----
package xtea_pkg;

  // Word width of the block halves and of each key word.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_WORDS = 4;

  // Round constant and default number of cycles (two half-rounds each).
  localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;
  localparam int unsigned ROUND_CYCLES_DEF = 32;

  // Key index selection: low bits of the sum, or the two bits from bit 11 up.
  localparam int unsigned KEY_SEL_SHIFT = 11;
  localparam logic [1:0] KEY_SEL_MASK = 2'd3;

  // Configuration address width and register indexes.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_KEY_WORD0 = 2'd0;
  localparam logic [1:0] REG_KEY_WORD1 = 2'd1;
  localparam logic [1:0] REG_KEY_WORD2 = 2'd2;
  localparam logic [1:0] REG_KEY_WORD3 = 2'd3;

  // Request kinds carried in tuser.
  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] xtea_key_t;

  // Payload that travels down the chain of half-round cells.
  typedef struct packed {
    logic              req_type;
    logic [WORD_W-1:0] block_word0;
    logic [WORD_W-1:0] block_word1;
  } xtea_stage_t;

  // Running sum after n steps of delta, modulo 2^32.
  function automatic logic [WORD_W-1:0] round_sum(input int unsigned n);
    logic [2*WORD_W-1:0] prod;
    prod = (2*WORD_W)'(n) * (2*WORD_W)'(XTEA_DELTA);
    return prod[WORD_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/xtea_block_cipher.sv -----
// XTEA block cipher, one 64-bit block per transfer, as a chain of half-round cells.
// The first cell loads a block at the input transfer; the block then passes through each
// further cell and the output register, which drives out_tvalid.
// Throughput: one block per cycle; the chain stalls only while its last cell and the
// output register both hold a block that the consumer does not take.
// Reset (rst_n, synchronous): key words clear to zero and the chain empties.
module xtea_block_cipher #(
  parameter int unsigned ROUND_CYCLES = xtea_pkg::ROUND_CYCLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2*xtea_pkg::WORD_W-1:0]       in_tdata,  // block_word0, block_word1
  input  logic                                in_tuser,  // req_type
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [2*xtea_pkg::WORD_W-1:0]       out_tdata, // result_word0, result_word1
  // Configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [xtea_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [xtea_pkg::WORD_W-1:0]         cfg_pwdata,
  output logic [xtea_pkg::WORD_W-1:0]         cfg_prdata,
  output logic                                cfg_pready
);
  import xtea_pkg::*;

  localparam int unsigned STAGES = 2 * ROUND_CYCLES;

  xtea_key_t         key;
  logic              adv;
  logic              valid_s [0:STAGES];
  xtea_stage_t       data_s  [0:STAGES];
  logic              out_valid_r;
  logic [WORD_W-1:0] out_w0_r;
  logic [WORD_W-1:0] out_w1_r;

  // Key words behind the configuration port.
  xtea_key_regs u_key_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .key         (key)
  );

  // The chain advances unless a finished block waits on a full output register.
  assign adv       = !valid_s[STAGES] || !out_valid_r || out_tready;
  assign in_tready = adv;

  assign valid_s[0]             = in_tvalid;
  assign data_s[0].req_type     = in_tuser;
  assign data_s[0].block_word0  = in_tdata[WORD_W-1:0];
  assign data_s[0].block_word1  = in_tdata[2*WORD_W-1:WORD_W];

  // One cell per half-round.
  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    xtea_cell #(
      .STAGE        (g),
      .ROUND_CYCLES (ROUND_CYCLES)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .key       (key),
      .valid_in  (valid_s[g]),
      .stage_in  (data_s[g]),
      .valid_out (valid_s[g+1]),
      .stage_out (data_s[g+1])
    );
  end

  // Output register; holds a block until the consumer takes the transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && valid_s[STAGES]) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_s[STAGES]) begin
      out_w0_r <= data_s[STAGES].block_word0;
      out_w1_r <= data_s[STAGES].block_word1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_w1_r, out_w0_r};

  // The input side is held off only by a blocked block at the end of the chain.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
      !in_tready |-> (valid_s[STAGES] && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  // A block leaving the chain always lands in the output register.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
      (adv && valid_s[STAGES]) |=> out_valid_r)
    else $error("finished block lost at the output register");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
      !rst_n |=> (!out_valid_r && !valid_s[1]))
    else $error("result pending after reset");

endmodule

// ----- hw/rtl/xtea_key_regs.sv -----
module xtea_key_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [xtea_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [xtea_pkg::WORD_W-1:0]       cfg_pwdata,
  output logic [xtea_pkg::WORD_W-1:0]       cfg_prdata,
  output logic                              cfg_pready,
  output xtea_pkg::xtea_key_t               key
);
  import xtea_pkg::*;

  xtea_key_t  key_r;
  xtea_key_t  key_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  // A write transfer replaces the addressed key word.
  always_comb begin
    key_nxt = key_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_KEY_WORD0: key_nxt[0] = cfg_pwdata;
        REG_KEY_WORD1: key_nxt[1] = cfg_pwdata;
        REG_KEY_WORD2: key_nxt[2] = cfg_pwdata;
        REG_KEY_WORD3: key_nxt[3] = cfg_pwdata;
        default:       key_nxt = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  // Read data follows the address.
  always_comb begin
    unique case (reg_idx)
      REG_KEY_WORD0: cfg_prdata = key_r[0];
      REG_KEY_WORD1: cfg_prdata = key_r[1];
      REG_KEY_WORD2: cfg_prdata = key_r[2];
      REG_KEY_WORD3: cfg_prdata = key_r[3];
      default:       cfg_prdata = '0;
    endcase
  end

  assign key = key_r;

endmodule

// ----- hw/rtl/xtea_cell.sv -----
module xtea_cell #(
  parameter int unsigned STAGE        = 0,
  parameter int unsigned ROUND_CYCLES = xtea_pkg::ROUND_CYCLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  xtea_pkg::xtea_key_t   key,
  input  logic                  valid_in,
  input  xtea_pkg::xtea_stage_t stage_in,
  output logic                  valid_out,
  output xtea_pkg::xtea_stage_t stage_out
);
  import xtea_pkg::*;

  // Which half-round of which cycle this cell performs, in both directions.
  localparam int unsigned ODD = STAGE % 2;
  localparam int unsigned CYC = STAGE / 2;
  localparam logic [WORD_W-1:0] SUM_ENC = round_sum(CYC + ODD);
  localparam logic [WORD_W-1:0] SUM_DEC = round_sum(ROUND_CYCLES - CYC - ODD);
  localparam logic [1:0] KI_ENC = (ODD == 1) ?
      SUM_ENC[KEY_SEL_SHIFT+1:KEY_SEL_SHIFT] : (SUM_ENC[1:0] & KEY_SEL_MASK);
  localparam logic [1:0] KI_DEC = (ODD == 1) ?
      (SUM_DEC[1:0] & KEY_SEL_MASK) : SUM_DEC[KEY_SEL_SHIFT+1:KEY_SEL_SHIFT];
  localparam logic ODD_BIT = (ODD == 1);

  logic              dec;
  logic              upd_w0;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] rkey;
  logic [WORD_W-1:0] f;
  logic [WORD_W-1:0] dst_new;
  xtea_stage_t       stage_nxt;
  logic              valid_r;
  xtea_stage_t       stage_r;

  // Encryption updates word 0 in even cells; decryption works the other way round.
  assign dec    = (stage_in.req_type == REQ_DECRYPT);
  assign upd_w0 = (dec == ODD_BIT);
  assign src    = upd_w0 ? stage_in.block_word1 : stage_in.block_word0;
  assign dst    = upd_w0 ? stage_in.block_word0 : stage_in.block_word1;

  // Half-round function.
  assign mix     = ((src << 4) ^ (src >> 5)) + src;
  assign rkey    = dec ? (SUM_DEC + key[KI_DEC]) : (SUM_ENC + key[KI_ENC]);
  assign f       = mix ^ rkey;
  assign dst_new = dec ? (dst - f) : (dst + f);

  always_comb begin
    stage_nxt = stage_in;
    if (upd_w0) begin
      stage_nxt.block_word0 = dst_new;
    end else begin
      stage_nxt.block_word1 = dst_new;
    end
  end

  // Stage register; the whole chain moves together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign valid_out = valid_r;
  assign stage_out = stage_r;

endmodule

// ----- verif/xtea_block_cipher_tb.sv -----
`timescale 1ns / 100ps

module xtea_block_cipher_tb;
  import xtea_pkg::*;

  localparam int unsigned ROUND_COUNT = ROUND_CYCLES_DEF;
  localparam int unsigned PIPE_LATENCY = 2 * ROUND_COUNT;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_PERCENT = 21;
  localparam int unsigned MAX_REPORTS = 40;

  // Key register indexes in the order of the key words.
  localparam logic [1:0] KEY_REGS [KEY_WORDS] = '{REG_KEY_WORD0, REG_KEY_WORD1,
                                                  REG_KEY_WORD2, REG_KEY_WORD3};

  // One 64-bit block, packed as it travels in tdata.
  typedef struct packed {
    logic [WORD_W-1:0] word1;
    logic [WORD_W-1:0] word0;
  } xtea_block_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [2*WORD_W-1:0]     in_tdata = '0;  // block_word0, block_word1
  logic                    in_tuser = REQ_ENCRYPT;  // req_type
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [2*WORD_W-1:0]     out_tdata;      // result_word0, result_word1
  logic                    cfg_psel = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_paddr = '0;
  logic [WORD_W-1:0]       cfg_pwdata = '0;
  logic [WORD_W-1:0]       cfg_prdata;
  logic                    cfg_pready;

  // Key as the block should currently hold it.
  logic [WORD_W-1:0]       cipher_key [KEY_WORDS];
  xtea_block_t             predicted_blocks [$];
  xtea_block_t             head_blk;

  bit                      send_idle_en = 1'b1;
  bit                      recv_stall_en = 1'b1;
  int unsigned             err_count = 0;
  int unsigned             cycle_count = 0;
  int unsigned             encrypt_count = 0;
  int unsigned             decrypt_count = 0;
  int unsigned             key_settings = 1;
  int unsigned             results_checked = 0;

  xtea_block_cipher i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $realtime,
               predicted_blocks.size());
      $display("xtea_block_cipher_tb: FAIL");
      $finish;
    end
  end

  // XTEA mixing term of one half-round.
  function automatic logic [WORD_W-1:0] feistel_mix(input logic [WORD_W-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // Expected output block for one request under the current key.
  function automatic xtea_block_t xtea_transform(input logic req,
                                                 input logic [WORD_W-1:0] w0,
                                                 input logic [WORD_W-1:0] w1);
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
    xtea_block_t       blk;
    v0 = w0;
    v1 = w1;
    sum = '0;
    if (req == REQ_ENCRYPT) begin
      for (int i = 0; i < ROUND_COUNT; i++) begin
        v0 = v0 + (feistel_mix(v1) ^ (sum + cipher_key[sum[1:0]]));
        sum = sum + XTEA_DELTA;
        v1 = v1 + (feistel_mix(v0) ^ (sum + cipher_key[sum[12:11]]));
      end
    end else begin
      // Decryption starts from the sum that encryption ends with.
      for (int i = 0; i < ROUND_COUNT; i++) begin
        sum = sum + XTEA_DELTA;
      end
      for (int i = 0; i < ROUND_COUNT; i++) begin
        v1 = v1 - (feistel_mix(v0) ^ (sum + cipher_key[sum[12:11]]));
        sum = sum - XTEA_DELTA;
        v0 = v0 - (feistel_mix(v1) ^ (sum + cipher_key[sum[1:0]]));
      end
    end
    blk.word0 = v0;
    blk.word1 = v1;
    return blk;
  endfunction

  // Word with a bias towards the extremes and single set or clear bits.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(11))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(31);
      3: return ~(32'd1 << $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  // Result side: check each transfer and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_blocks.size() == 0) begin
        err_count++;
        if (err_count < MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $realtime, out_tdata);
      end else begin
        head_blk = predicted_blocks.pop_front();
        results_checked <= results_checked + 1;
        if (out_tdata[WORD_W-1:0] !== head_blk.word0) begin
          err_count++;
          if (err_count < MAX_REPORTS)
            $display("%0t: result_word0 mismatch, expected %h, actual %h", $realtime,
                     head_blk.word0, out_tdata[WORD_W-1:0]);
        end
        if (out_tdata[2*WORD_W-1:WORD_W] !== head_blk.word1) begin
          err_count++;
          if (err_count < MAX_REPORTS)
            $display("%0t: result_word1 mismatch, expected %h, actual %h", $realtime,
                     head_blk.word1, out_tdata[2*WORD_W-1:WORD_W]);
        end
      end
    end
    out_tready <= recv_stall_en ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
  end

  // One configuration transfer: setup cycle, then access until pready.
  task automatic cfg_access(input logic wr, input logic [1:0] idx,
                            input logic [WORD_W-1:0] wdata, output logic [WORD_W-1:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Read a key register back and compare it with the expected key word.
  task automatic check_key_word(input int unsigned n);
    logic [WORD_W-1:0] rdata;
    cfg_access(1'b0, KEY_REGS[n], '0, rdata);
    if (rdata !== cipher_key[n]) begin
      err_count++;
      $display("%0t: key_word%0d read-back mismatch, expected %h, actual %h", $realtime, n,
               cipher_key[n], rdata);
    end
  endtask

  // Load a whole key; only called while nothing is in flight.
  task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                          input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
    logic [WORD_W-1:0] words [KEY_WORDS];
    logic [WORD_W-1:0] rdata;
    words = '{k0, k1, k2, k3};
    for (int n = 0; n < KEY_WORDS; n++) begin
      cfg_access(1'b1, KEY_REGS[n], words[n], rdata);
      cipher_key[n] = words[n];
      check_key_word(n);
    end
    key_settings++;
  endtask

  // Lower valid and hold off until every predicted result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (predicted_blocks.size() != 0);
  endtask

  // Offer one request and wait for its transfer; valid is left high on return.
  task automatic send_block(input logic req, input logic [WORD_W-1:0] w0,
                            input logic [WORD_W-1:0] w1);
    while (send_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      in_tdata <= {$urandom(), $urandom()};
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {w1, w0};
    do @(posedge clk); while (!in_tready);
    predicted_blocks.push_back(xtea_transform(req, w0, w1));
    if (req == REQ_ENCRYPT)
      encrypt_count++;
    else
      decrypt_count++;
  endtask

  task automatic send_random(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      send_block($urandom_range(1) ? REQ_DECRYPT : REQ_ENCRYPT, pick_word(), pick_word());
    end
  endtask

  // Key after reset must read as zero; extreme blocks under that key.
  task automatic test_reset_key();
    for (int n = 0; n < KEY_WORDS; n++) begin
      check_key_word(n);
    end
    send_block(REQ_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(REQ_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(REQ_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(REQ_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(REQ_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(REQ_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_block(REQ_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
    send_block(REQ_DECRYPT, 32'h8000_0000, 32'h0000_0001);
    wait_drained();
  endtask

  // All-ones and patterned keys with directed blocks.
  task automatic test_key_extremes();
    load_key('1, '1, '1, '1);
    send_block(REQ_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_block(REQ_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_block(REQ_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
    send_block(REQ_DECRYPT, 32'h89AB_CDEF, 32'h0123_4567);
    wait_drained();
    load_key(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000, 32'h8000_0001);
    send_block(REQ_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(REQ_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(REQ_ENCRYPT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_block(REQ_DECRYPT, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_drained();
  endtask

  // Random requests under a random key with idling on both sides.
  task automatic test_random_traffic();
    load_key(pick_word(), pick_word(), pick_word(), pick_word());
    send_random(300);
    wait_drained();
  endtask

  // A long stretch at full rate: no source gaps, no result stalls.
  task automatic test_back_to_back();
    send_idle_en = 1'b0;
    recv_stall_en = 1'b0;
    load_key($urandom(), $urandom(), $urandom(), $urandom());
    send_random(250);
    wait_drained();
    send_idle_en = 1'b1;
    recv_stall_en = 1'b1;
  endtask

  // Bursts of requests, each followed by a full drain; the key changes now and then.
  task automatic test_drain_pauses();
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < 200) begin
      burst = $urandom_range(1, 40);
      send_random(burst);
      sent += burst;
      wait_drained();
      if ($urandom_range(2) == 0)
        load_key(pick_word(), pick_word(), pick_word(), pick_word());
    end
  endtask

  // Several keys with a single live word, then an all-zero key.
  task automatic test_mixed_keys();
    for (int n = 0; n < KEY_WORDS; n++) begin
      load_key(n == 0 ? $urandom() : '0, n == 1 ? $urandom() : '0,
               n == 2 ? $urandom() : '0, n == 3 ? $urandom() : '0);
      send_random(40);
      wait_drained();
    end
    load_key('0, '0, '0, '0);
    send_random(40);
    wait_drained();
  endtask

  initial begin
    for (int n = 0; n < KEY_WORDS; n++) begin
      cipher_key[n] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_key();
    test_key_extremes();
    test_random_traffic();
    test_back_to_back();
    test_drain_pauses();
    test_mixed_keys();

    // Allow any stray result to surface before the verdict.
    wait_drained();
    repeat (2 * PIPE_LATENCY + 20) @(posedge clk);

    $display("Sent %0d encrypt and %0d decrypt requests under %0d key settings.",
             encrypt_count, decrypt_count, key_settings);
    $display("Checked %0d results, with and without random idling on both streams.",
             results_checked);
    if (err_count == 0) begin
      $display("xtea_block_cipher_tb: PASS");
    end else begin
      $display("xtea_block_cipher_tb: FAIL");
    end
    $finish;
  end

endmodule
